// File: src/tmes_pkg.sv
package tmes_pkg;

	// program pointer width, fixed by the 12-bit address fields
	localparam int PC_W = 12;
	localparam int CELL_W = 8;
	localparam int TAPE_DEPTH_DEF = 4096;

	typedef logic [PC_W-1:0] pc_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_RIGHT = 4'd2,
		OP_LEFT  = 4'd3,
		OP_READ  = 4'd4,
		OP_WRITE = 4'd5,
		OP_OPEN  = 4'd6,
		OP_CLOSE = 4'd7
	} op_t;

endpackage

// File: src/tape_machine_execute_step.sv
// channel | handshake                   | fields
// item    | item_valid / item_ready     | opcode, jump_distance, in_byte
// result  | result_valid / result_ready | next_address, out_byte, out_valid, bad_opcode
//
// one instruction per cycle sustained while results are taken: the tape read is
// issued at acceptance, the cell update, write-back and branch resolve in the
// execute stage, and the result is registered as that stage advances.
// after reset the tape is swept to zero, one cell a cycle, with item_ready low
// during the sweep. a stalled result holds the execute stage and input.
module tape_machine_execute_step import tmes_pkg::*; #(
	parameter int TAPE_DEPTH = TAPE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [3:0]        opcode,
	input  logic [PC_W-1:0]   jump_distance,
	input  logic [CELL_W-1:0] in_byte,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [PC_W-1:0]   next_address,
	output logic [CELL_W-1:0] out_byte,
	output logic              out_valid,
	output logic              bad_opcode
);

	localparam int CP_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
	localparam logic [CP_W-1:0] CP_LAST = CP_W'(TAPE_DEPTH - 1);

	cell_t tape_mem [TAPE_DEPTH];

	logic            clr_active_q;
	logic [CP_W-1:0] clr_idx_q;
	logic [CP_W-1:0] cp_q;
	pc_t             pp_q;

	logic            v_s1;
	op_t             op_s1;
	pc_t             dist_s1;
	cell_t           byte_s1;
	logic [CP_W-1:0] addr_s1;
	cell_t           cell_rd_s1;
	logic            fwd_s1;
	cell_t           fwd_data_s1;

	logic            res_valid_q;
	pc_t             next_address_q;
	cell_t           out_byte_q;
	logic            out_valid_q;
	logic            bad_opcode_q;

	logic            accept;
	logic            s1_adv;
	op_t             op_in;
	cell_t           cur_cell;
	cell_t           new_cell;
	logic            wr_s1;
	logic            emit_s1;
	logic            bad_s1;
	pc_t             pp_next;
	logic [CP_W-1:0] cp_next;

	assign s1_adv     = v_s1 && (!res_valid_q || result_ready);
	assign item_ready = !clr_active_q && (!v_s1 || s1_adv);
	assign accept     = item_valid && item_ready;
	assign op_in      = op_t'(opcode);

	// pointer moves only depend on the opcode, so they resolve at acceptance
	always_comb begin
		cp_next = cp_q;
		case (op_in)
			OP_RIGHT: cp_next = (cp_q == CP_LAST) ? '0 : cp_q + 1'b1;
			OP_LEFT:  cp_next = (cp_q == '0) ? CP_LAST : cp_q - 1'b1;
			default:  cp_next = cp_q;
		endcase
	end

	// execute stage
	always_comb begin
		cur_cell = fwd_s1 ? fwd_data_s1 : cell_rd_s1;
		new_cell = cur_cell;
		wr_s1    = 1'b0;
		emit_s1  = 1'b0;
		bad_s1   = 1'b0;
		pp_next  = pp_q + 1'b1;
		case (op_s1)
			OP_ADD: begin
				wr_s1    = 1'b1;
				new_cell = cur_cell + 1'b1;
			end
			OP_SUB: begin
				wr_s1    = 1'b1;
				new_cell = cur_cell - 1'b1;
			end
			OP_RIGHT, OP_LEFT: begin
				wr_s1 = 1'b0;
			end
			OP_READ: begin
				wr_s1    = 1'b1;
				new_cell = byte_s1;
			end
			OP_WRITE: begin
				emit_s1 = 1'b1;
			end
			OP_OPEN: begin
				if (cur_cell == '0) begin
					pp_next = pp_q + dist_s1 + 1'b1;
				end
			end
			OP_CLOSE: begin
				if (cur_cell != '0) begin
					pp_next = pp_q - dist_s1 + 1'b1;
				end
			end
			default: begin
				bad_s1 = 1'b1;
			end
		endcase
	end

	// tape write port: clearing sweep, then execute-stage write-back
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			tape_mem[clr_idx_q] <= '0;
		end else if (s1_adv && wr_s1) begin
			tape_mem[addr_s1] <= new_cell;
		end
	end

	// tape read port
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_rd_s1 <= tape_mem[cp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == CP_LAST) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cp_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				cp_q <= cp_next;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// payload of the execute stage, with forwarding of a write landing this edge
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_in;
			dist_s1     <= jump_distance;
			byte_s1     <= in_byte;
			addr_s1     <= cp_q;
			fwd_s1      <= v_s1 && wr_s1 && (addr_s1 == cp_q);
			fwd_data_s1 <= new_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				pp_q        <= pp_next;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			next_address_q <= pp_next;
			out_byte_q     <= emit_s1 ? cur_cell : '0;
			out_valid_q    <= emit_s1;
			bad_opcode_q   <= bad_s1;
		end
	end

	assign result_valid = res_valid_q;
	assign next_address = next_address_q;
	assign out_byte     = out_byte_q;
	assign out_valid    = out_valid_q;
	assign bad_opcode   = bad_opcode_q;

endmodule

// File: src/tmes_chk.sv
module tmes_chk import tmes_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [PC_W-1:0]   next_address,
	input logic [CELL_W-1:0] out_byte,
	input logic              out_valid,
	input logic              bad_opcode
);

	// a stalled result transaction keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(next_address)
			&& $stable(out_byte) && $stable(out_valid) && $stable(bad_opcode))
	else $error("stalled result changed");

	// a write command is never also flagged as a bad opcode
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(out_valid && bad_opcode))
	else $error("write and bad opcode together");

	// non-write steps emit a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_valid |-> out_byte == '0)
	else $error("byte emitted without write");

	// no result can appear in the cycle right after reset is released
	assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid && !item_ready)
	else $error("activity during tape clearing");

endmodule

bind tape_machine_execute_step tmes_chk u_tmes_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.next_address (next_address),
	.out_byte     (out_byte),
	.out_valid    (out_valid),
	.bad_opcode   (bad_opcode)
);
